// ===== design/pl0_pkg.sv =====
// pl0 p-code machine package: opcodes, operator codes, fault codes, sequencer states
// no dependencies
`default_nettype none
package pl0_pkg;
	typedef enum logic [2:0] {
		OP_LIT = 3'd0, OP_OPR = 3'd1, OP_LOD = 3'd2, OP_STO = 3'd3,
		OP_CAL = 3'd4, OP_INT = 3'd5, OP_JMP = 3'd6, OP_JPC = 3'd7
	} opcode_t;

	localparam logic [10:0] OPR_RET = 11'd0;
	localparam logic [10:0] OPR_NEG = 11'd1;
	localparam logic [10:0] OPR_ADD = 11'd2;
	localparam logic [10:0] OPR_SUB = 11'd3;
	localparam logic [10:0] OPR_MUL = 11'd4;
	localparam logic [10:0] OPR_DIV = 11'd5;
	localparam logic [10:0] OPR_ODD = 11'd6;
	localparam logic [10:0] OPR_EQL = 11'd8;
	localparam logic [10:0] OPR_NEQ = 11'd9;
	localparam logic [10:0] OPR_LSS = 11'd10;
	localparam logic [10:0] OPR_GEQ = 11'd11;
	localparam logic [10:0] OPR_GTR = 11'd12;
	localparam logic [10:0] OPR_LEQ = 11'd13;

	localparam logic [1:0] FLT_NONE  = 2'd0;
	localparam logic [1:0] FLT_DIV0  = 2'd1;
	localparam logic [1:0] FLT_OVER  = 2'd2;
	localparam logic [1:0] FLT_UNDER = 2'd3;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_RD    = 10'b0000000010,
		S_WAIT  = 10'b0000000100,
		S_WALK  = 10'b0000001000,
		S_EXEC  = 10'b0000010000,
		S_DIV   = 10'b0000100000,
		S_WR    = 10'b0001000000,
		S_FIN   = 10'b0010000000,
		S_TOPW  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;
endpackage
`default_nettype wire

// ===== design/pl0_if.sv =====
// valid/ready channel interface carrying a generic payload
// depends on nothing
`default_nettype none
interface pl0_if #(parameter type payload_t = logic) (input wire logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/pl0_div.sv =====
// serial signed divider, one quotient bit a cycle, truncating toward zero
// depends on nothing
`default_nettype none
module pl0_div #(
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [WORD_WIDTH-1:0] dividend,
	input  wire logic [WORD_WIDTH-1:0] divisor,
	output logic                       done,
	output logic      [WORD_WIDTH-1:0] quotient
);
	localparam int CW = $clog2(WORD_WIDTH + 1);
	logic [WORD_WIDTH-1:0] rem_q, quo_q, dsr_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q, neg_q;
	logic [WORD_WIDTH:0]   trial;

	assign trial = {rem_q, quo_q[WORD_WIDTH-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WORD_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[WORD_WIDTH-1] ? -dividend : dividend;
			dsr_q <= divisor[WORD_WIDTH-1] ? -divisor : divisor;
			neg_q <= dividend[WORD_WIDTH-1] ^ divisor[WORD_WIDTH-1];
		end else if (busy_q) begin
			if (!trial[WORD_WIDTH]) begin
				rem_q <= trial[WORD_WIDTH-1:0];
				quo_q <= {quo_q[WORD_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[WORD_WIDTH-2:0], quo_q[WORD_WIDTH-1]};
				quo_q <= {quo_q[WORD_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -quo_q : quo_q;
endmodule
`default_nettype wire

// ===== design/pl0_pcode_stack_machine.sv =====
// pl/0 p-code stack machine: one instruction per request, one result per request
// a divide runs the serial divider; a call walks the static links, then writes three words
// one instruction in flight at a time: a request is taken only in idle, after the last result
// reset clears pc and base to 0, top to -1 and stack entries 1 to 3 in a clearing pass
// depends on pl0_pkg, pl0_if, pl0_div
`default_nettype none
module pl0_pcode_stack_machine
	import pl0_pkg::*;
#(
	parameter int STACK_DEPTH = 4096,
	parameter int CODE_SIZE   = 2048,
	parameter int MAX_LEVEL   = 3,
	parameter int WORD_WIDTH  = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	pl0_if.sink      instr,
	pl0_if.source    result
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int PW = $clog2(CODE_SIZE);
	localparam int TW = AW + 1;
	localparam int XW = AW + 13;

	// request fields
	logic [2:0]  in_op;
	logic [1:0]  in_lev;
	logic [10:0] in_ad;
	assign in_op  = instr.data.opcode;
	assign in_lev = instr.data.level;
	assign in_ad  = instr.data.addr;

	state_t state_q;
	logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];
	logic [WORD_WIDTH-1:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic [WORD_WIDTH-1:0] wdata;
	logic re, we;

	logic [PW-1:0] pc_q;
	logic [AW-1:0] base_q, bb_q;
	logic signed [TW-1:0] top_q;
	logic [2:0]  op_q;
	logic [1:0]  lev_q;
	logic [10:0] ad_q;
	logic [1:0]  flt_q;
	logic [1:0]  step_q;   // which operand or call word is in progress
	logic [WORD_WIDTH-1:0] a_q, b_q;
	logic [1:0]  clr_q;
	logic        clr_busy_q;
	logic [WORD_WIDTH-1:0] topv_q;

	// memory, read data registered
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	// single serial divider
	logic div_start, div_done;
	logic [WORD_WIDTH-1:0] div_q;
	pl0_div #(.WORD_WIDTH(WORD_WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(a_q), .divisor(b_q), .done(div_done), .quotient(div_q)
	);

	// helpers
	logic signed [XW-1:0] t_x, b_x, ad_x;
	assign t_x  = XW'(top_q);
	assign b_x  = XW'({1'b0, base_q});
	assign ad_x = XW'({1'b0, ad_q});
	localparam logic signed [XW-1:0] LASTX = XW'(STACK_DEPTH - 1);
	logic signed [XW-1:0] walk_idx;
	assign walk_idx = XW'({1'b0, bb_q}) + ad_x;

	logic is_bin, is_un;
	assign is_un  = ad_q inside {OPR_NEG, OPR_ODD};
	assign is_bin = ad_q inside {[OPR_ADD:OPR_DIV], [OPR_EQL:OPR_LEQ]};

	logic [WORD_WIDTH-1:0] sgn;
	assign sgn = {1'b1, {(WORD_WIDTH-1){1'b0}}};
	logic lt_ab, lt_ba;
	assign lt_ab = (a_q ^ sgn) < (b_q ^ sgn);
	assign lt_ba = (b_q ^ sgn) < (a_q ^ sgn);

	// one shared alu result, a single multiplier
	logic [WORD_WIDTH-1:0] alu;
	always_comb begin
		case (ad_q)
			OPR_ADD: alu = a_q + b_q;
			OPR_SUB: alu = a_q - b_q;
			OPR_MUL: alu = a_q * b_q;
			OPR_EQL: alu = WORD_WIDTH'(a_q == b_q);
			OPR_NEQ: alu = WORD_WIDTH'(a_q != b_q);
			OPR_LSS: alu = WORD_WIDTH'(lt_ab);
			OPR_GEQ: alu = WORD_WIDTH'(!lt_ab);
			OPR_GTR: alu = WORD_WIDTH'(lt_ba);
			OPR_LEQ: alu = WORD_WIDTH'(!lt_ba);
			OPR_NEG: alu = -a_q;
			OPR_ODD: alu = WORD_WIDTH'(a_q[0]);
			default: alu = a_q;
		endcase
	end

	logic [1:0] lev_sat;
	assign lev_sat = (MAX_LEVEL < 3 && in_lev > 2'(MAX_LEVEL)) ? 2'(MAX_LEVEL) : in_lev;

	// memory port control, combinational per state
	always_comb begin
		re = 1'b0; we = 1'b0; raddr = '0; waddr = '0; wdata = '0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (clr_busy_q) begin
					we = 1'b1; waddr = AW'(clr_q); wdata = '0;
				end
			end
			S_RD: begin
				re = 1'b1;
				case (op_q)
					// return: saved pc at base+2 first, then the dynamic link at base+1
					OP_OPR: raddr = (ad_q == OPR_RET) ? base_q + AW'(2) - AW'(step_q)
						: (step_q == 2'd0 ? top_q[AW-1:0] : top_q[AW-1:0] - AW'(1));
					OP_LOD, OP_STO, OP_CAL: raddr = bb_q;
					OP_JPC: raddr = top_q[AW-1:0];
					default: raddr = top_q[AW-1:0];
				endcase
			end
			S_EXEC: begin
				if (op_q == OP_OPR && ad_q == OPR_DIV && b_q != '0) div_start = 1'b1;
				else if (op_q == OP_LOD || op_q == OP_STO) begin
					re = 1'b1;
					raddr = (op_q == OP_LOD) ? walk_idx[AW-1:0] : top_q[AW-1:0];
				end
			end
			S_WR: begin
				we = 1'b1;
				case (op_q)
					OP_LIT: begin waddr = top_q[AW-1:0]; wdata = WORD_WIDTH'(ad_q); end
					OP_LOD: begin waddr = top_q[AW-1:0]; wdata = rdata_q; end
					OP_STO: begin waddr = walk_idx[AW-1:0]; wdata = rdata_q; end
					OP_CAL: begin
						waddr = top_q[AW-1:0] + AW'(step_q) + AW'(1);
						wdata = (step_q == 2'd0) ? WORD_WIDTH'(bb_q)
							: (step_q == 2'd1) ? WORD_WIDTH'(base_q) : WORD_WIDTH'(pc_q);
					end
					default: begin
						waddr = top_q[AW-1:0];
						wdata = (ad_q == OPR_DIV) ? ((b_q == '0) ? '0 : div_q) : alu;
					end
				endcase
			end
			S_TOPW: begin
				re = 1'b1; raddr = top_q[AW-1:0];
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pc_q       <= '0;
			base_q     <= '0;
			top_q      <= '1;
			clr_q      <= 2'd1;
			clr_busy_q <= 1'b1;
			flt_q      <= FLT_NONE;
			step_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (clr_busy_q) begin
						clr_q <= clr_q + 2'd1;
						if (clr_q == 2'd3) clr_busy_q <= 1'b0;
					end else if (instr.valid) begin
						op_q   <= in_op;
						lev_q  <= lev_sat;
						ad_q   <= in_ad;
						bb_q   <= base_q;
						step_q <= '0;
						flt_q  <= FLT_NONE;
						pc_q   <= pc_q + PW'(1);
						state_q <= S_EXEC;
						case (opcode_t'(in_op))
							OP_OPR: if (in_ad inside {OPR_RET, OPR_NEG, OPR_ODD,
								[OPR_ADD:OPR_DIV], [OPR_EQL:OPR_LEQ]}) state_q <= S_RD;
							OP_LOD, OP_STO, OP_CAL: state_q <= (lev_sat != 2'd0) ? S_RD : S_EXEC;
							OP_JPC: state_q <= S_RD;
							default: state_q <= S_EXEC;
						endcase
					end
				end
				S_RD: begin
					// underflow and overflow checks in the state that issues the first read
					if (op_q == OP_OPR && ad_q == OPR_RET && step_q == 2'd0
						&& b_x + XW'(2) > LASTX) begin
						flt_q <= FLT_OVER; state_q <= S_TOPW;
					end else if (op_q == OP_OPR && ad_q != OPR_RET && step_q == 2'd0
						&& ((is_un && top_q < 0) || (is_bin && top_q < 1))) begin
						flt_q <= FLT_UNDER; state_q <= S_TOPW;
					end else if (op_q == OP_JPC && top_q < 0) begin
						flt_q <= FLT_UNDER; state_q <= S_TOPW;
					end else state_q <= S_WAIT;
				end
				S_WAIT: begin
					case (op_q)
						OP_LOD, OP_STO, OP_CAL: begin
							bb_q  <= rdata_q[AW-1:0];
							lev_q <= lev_q - 2'd1;
							state_q <= (lev_q == 2'd1) ? S_EXEC : S_RD;
						end
						OP_JPC: begin
							if (rdata_q == WORD_WIDTH'(1)) pc_q <= PW'(ad_q);
							top_q <= top_q - TW'(1);
							state_q <= S_TOPW;
						end
						default: begin
							if (ad_q == OPR_RET) begin
								if (step_q == 2'd0) begin
									pc_q <= rdata_q[PW-1:0];
									step_q <= 2'd1; state_q <= S_RD;
								end else begin
									top_q  <= TW'({1'b0, base_q}) - TW'(1);
									base_q <= rdata_q[AW-1:0];
									state_q <= S_TOPW;
								end
							end else if (is_un) begin
								a_q <= rdata_q; state_q <= S_WR;
							end else if (step_q == 2'd0) begin
								b_q <= rdata_q; step_q <= 2'd1; state_q <= S_RD;
							end else begin
								a_q <= rdata_q;
								top_q <= top_q - TW'(1);
								state_q <= S_EXEC;
							end
						end
					endcase
				end
				S_EXEC: begin
					case (op_q)
						OP_LIT: if (t_x + XW'(1) > LASTX) begin
								flt_q <= FLT_OVER; state_q <= S_TOPW;
							end else begin
								top_q <= top_q + TW'(1); state_q <= S_WR;
							end
						// unknown operators leave the stack untouched
						OP_OPR: if (!is_bin) state_q <= S_TOPW;
							else if (ad_q == OPR_DIV && b_q != '0) state_q <= S_DIV;
							else begin
								if (ad_q == OPR_DIV) flt_q <= FLT_DIV0;
								state_q <= S_WR;
							end
						OP_LOD: if (t_x + XW'(1) > LASTX || walk_idx > LASTX) begin
								flt_q <= FLT_OVER; state_q <= S_TOPW;
							end else begin
								top_q <= top_q + TW'(1); state_q <= S_FIN;
							end
						OP_STO: if (top_q < 0) begin
								flt_q <= FLT_UNDER; state_q <= S_TOPW;
							end else if (walk_idx > LASTX) begin
								flt_q <= FLT_OVER; state_q <= S_TOPW;
							end else state_q <= S_FIN;
						OP_CAL: if (t_x + XW'(3) > LASTX) begin
								flt_q <= FLT_OVER; state_q <= S_TOPW;
							end else state_q <= S_WR;
						OP_INT: begin
							if (t_x + ad_x > LASTX) flt_q <= FLT_OVER;
							else top_q <= top_q + TW'(ad_q);
							state_q <= S_TOPW;
						end
						OP_JMP: begin pc_q <= PW'(ad_q); state_q <= S_TOPW; end
						default: state_q <= S_TOPW;
					endcase
				end
				S_DIV: if (div_done) state_q <= S_WR;
				S_FIN: state_q <= S_WR;   // memory read of the copied word lands
				S_WR: begin
					if (op_q == OP_CAL) begin
						step_q <= step_q + 2'd1;
						if (step_q == 2'd2) begin
							base_q <= top_q[AW-1:0] + AW'(1);
							pc_q   <= PW'(ad_q);
							state_q <= S_TOPW;
						end
					end else begin
						if (op_q == OP_STO) top_q <= top_q - TW'(1);
						state_q <= S_TOPW;
					end
				end
				S_TOPW: state_q <= S_OUT;
				S_OUT: if (result.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// top value capture: the read issued in S_TOPW lands in S_OUT
	logic topv_load_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) topv_load_q <= 1'b0;
		else topv_load_q <= (state_q == S_TOPW);
	end
	always_ff @(posedge clk) begin
		if (topv_load_q) topv_q <= rdata_q;
	end
	logic out_ok_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ok_q <= 1'b0;
		else out_ok_q <= (state_q == S_OUT) && !result.ready ? 1'b1
			: (state_q == S_OUT ? 1'b0 : out_ok_q);
	end

	logic [WORD_WIDTH-1:0] topv_now;
	assign topv_now = (out_ok_q ? topv_q : rdata_q);

	assign instr.ready  = (state_q == S_IDLE) && !clr_busy_q;
	assign result.valid = (state_q == S_OUT);
	assign result.data.next_pc   = 11'(pc_q);
	assign result.data.top_index = 13'(top_q);
	assign result.data.top_value = (top_q < 0) ? 32'sd0 : 32'(signed'(topv_now));
	assign result.data.base_now  = 12'(base_q);
	assign result.data.halted    = (pc_q == '0);
	assign result.data.fault     = flt_q;

	// checks
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !instr.ready) else $error("ready while busy");
	a_div_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == S_EXEC)) else $error("divider started outside exec");
	a_result_after_topw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == S_TOPW)) else $error("result without top read");
endmodule
`default_nettype wire

// ===== dv/tb_pl0_pcode_stack_machine.sv =====
// self-checking testbench for the pl/0 p-code stack machine: directed table then random programs
// depends on pl0_pkg, pl0_if and the design top pl0_pcode_stack_machine
`timescale 1ns / 1ps
module tb_pl0_pcode_stack_machine;
	import pl0_pkg::*;

	// request and result payloads, first field in the upper bits
	typedef struct packed {
		opcode_t     opcode;
		logic [1:0]  level;
		logic [10:0] addr;
	} instr_t;

	typedef struct packed {
		logic [10:0] next_pc;
		logic [12:0] top_index;
		logic [31:0] top_value;
		logic [11:0] base_now;
		logic        halted;
		logic [1:0]  fault;
	} result_t;

	typedef struct {
		instr_t  ins;
		bit      typed;
		result_t want;
	} row_t;

	localparam int DEPTH     = 4096;
	localparam int TOP_ENTRY = DEPTH - 1;
	localparam int RAND_ITEMS = 550;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;

	pl0_if #(.payload_t(instr_t))  instr_ch (clk);
	pl0_if #(.payload_t(result_t)) result_ch (clk);

	pl0_pcode_stack_machine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	// machine image kept by the predictor
	logic [31:0] stack_mem [DEPTH];
	bit          stack_set [DEPTH];
	logic [10:0] pc_reg;
	logic [11:0] base_reg;
	int          top_reg;

	// undo log so a candidate instruction can be tried and rolled back
	int          undo_idx [$];
	logic [31:0] undo_val [$];
	bit          undo_set [$];
	bit          unset_read;

	result_t expected_results [$];
	row_t    directed_rows [$];
	int      fails;
	int      cycles;
	int      send_idle;
	int      recv_stall;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [31:0] stack_rd(int i);
		if (!stack_set[i])
			unset_read = 1'b1;
		return stack_mem[i];
	endfunction

	function automatic void stack_wr(int i, logic [31:0] v);
		undo_idx.push_back(i);
		undo_val.push_back(stack_mem[i]);
		undo_set.push_back(stack_set[i]);
		stack_mem[i] = v;
		stack_set[i] = 1'b1;
	endfunction

	// follow static links down lev frames
	function automatic int frame_base(int lev);
		int bb;
		logic [31:0] w;
		bb = base_reg;
		repeat (lev) begin
			w = stack_rd(bb);
			bb = w[11:0];
		end
		return bb;
	endfunction

	// executes one instruction on the image; rolled back unless commit is set
	function automatic void execute_instr(input instr_t ins, input bit commit,
			output result_t res, output bit unsafe);
		logic [10:0] pc_old;
		logic [11:0] base_old;
		int          top_old, t, idx;
		logic [31:0] a, b, r, ma, mb, q;
		logic [1:0]  flt;
		pc_old = pc_reg;
		base_old = base_reg;
		top_old = top_reg;
		undo_idx.delete();
		undo_val.delete();
		undo_set.delete();
		unset_read = 1'b0;
		flt = FLT_NONE;
		t = top_reg;
		pc_reg = pc_reg + 11'd1;
		case (ins.opcode)
			OP_LIT: begin
				if (t + 1 > TOP_ENTRY)
					flt = FLT_OVER;
				else begin
					t++;
					stack_wr(t, {21'd0, ins.addr});
				end
			end
			OP_OPR: begin
				if (ins.addr == OPR_RET) begin
					if (int'(base_reg) + 2 > TOP_ENTRY)
						flt = FLT_OVER;
					else begin
						t = int'(base_reg) - 1;
						a = stack_rd(base_reg + 2);
						b = stack_rd(base_reg + 1);
						pc_reg = a[10:0];
						base_reg = b[11:0];
					end
				end else if (ins.addr == OPR_NEG || ins.addr == OPR_ODD) begin
					if (t < 0)
						flt = FLT_UNDER;
					else begin
						a = stack_rd(t);
						stack_wr(t, (ins.addr == OPR_NEG) ? -a : {31'd0, a[0]});
					end
				end else if ((ins.addr >= OPR_ADD && ins.addr <= OPR_DIV) ||
						(ins.addr >= OPR_EQL && ins.addr <= OPR_LEQ)) begin
					if (t < 1)
						flt = FLT_UNDER;
					else begin
						t--;
						a = stack_rd(t);
						b = stack_rd(t + 1);
						r = '0;
						case (ins.addr)
							OPR_ADD: r = a + b;
							OPR_SUB: r = a - b;
							OPR_MUL: r = a * b;
							OPR_DIV: begin
								if (b == 0)
									flt = FLT_DIV0;
								else begin
									// magnitude divide, sign fixed after; wraps on min / -1
									ma = a[31] ? -a : a;
									mb = b[31] ? -b : b;
									q = ma / mb;
									r = (a[31] != b[31]) ? -q : q;
								end
							end
							OPR_EQL: r = {31'd0, a == b};
							OPR_NEQ: r = {31'd0, a != b};
							OPR_LSS: r = {31'd0, $signed(a) < $signed(b)};
							OPR_GEQ: r = {31'd0, $signed(a) >= $signed(b)};
							OPR_GTR: r = {31'd0, $signed(a) > $signed(b)};
							default: r = {31'd0, $signed(a) <= $signed(b)};
						endcase
						stack_wr(t, r);
					end
				end
				// unknown operator numbers leave everything but the pc alone
			end
			OP_LOD: begin
				if (t + 1 > TOP_ENTRY)
					flt = FLT_OVER;
				else begin
					idx = frame_base(ins.level) + ins.addr;
					if (idx > TOP_ENTRY)
						flt = FLT_OVER;
					else begin
						t++;
						stack_wr(t, stack_rd(idx));
					end
				end
			end
			OP_STO: begin
				if (t < 0)
					flt = FLT_UNDER;
				else begin
					idx = frame_base(ins.level) + ins.addr;
					if (idx > TOP_ENTRY)
						flt = FLT_OVER;
					else begin
						stack_wr(idx, stack_rd(t));
						t--;
					end
				end
			end
			OP_CAL: begin
				if (t + 3 > TOP_ENTRY)
					flt = FLT_OVER;
				else begin
					// activation mark: static link, dynamic link, return pc
					stack_wr(t + 1, frame_base(ins.level));
					stack_wr(t + 2, {20'd0, base_reg});
					stack_wr(t + 3, {21'd0, pc_reg});
					base_reg = 12'(t + 1);
					pc_reg = ins.addr;
				end
			end
			OP_INT: begin
				if (t + int'(ins.addr) > TOP_ENTRY)
					flt = FLT_OVER;
				else
					t += ins.addr;
			end
			OP_JMP: pc_reg = ins.addr;
			default: begin
				// conditional jump taken on a top value of exactly one
				if (t < 0)
					flt = FLT_UNDER;
				else begin
					if (stack_rd(t) == 32'd1)
						pc_reg = ins.addr;
					t--;
				end
			end
		endcase
		top_reg = t;
		res.next_pc = pc_reg;
		res.top_index = t[12:0];
		res.top_value = (t >= 0) ? stack_rd(t) : 32'd0;
		res.base_now = base_reg;
		res.halted = (pc_reg == 11'd0);
		res.fault = flt;
		unsafe = unset_read;
		if (!commit) begin
			for (int k = undo_idx.size() - 1; k >= 0; k--) begin
				stack_mem[undo_idx[k]] = undo_val[k];
				stack_set[undo_idx[k]] = undo_set[k];
			end
			pc_reg = pc_old;
			base_reg = base_old;
			top_reg = top_old;
		end
	endfunction

	function automatic void add_row(opcode_t op, int lev, int ad);
		row_t r;
		r.ins = '{opcode: op, level: lev[1:0], addr: ad[10:0]};
		r.typed = 1'b0;
		r.want = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_typed(opcode_t op, int lev, int ad, int pc, int t,
			logic [31:0] v, int bs, logic [1:0] flt);
		row_t r;
		r.ins = '{opcode: op, level: lev[1:0], addr: ad[10:0]};
		r.typed = 1'b1;
		r.want = '{next_pc: pc[10:0], top_index: t[12:0], top_value: v,
			base_now: bs[11:0], halted: (pc == 0), fault: flt};
		directed_rows.push_back(r);
	endfunction

	// random instruction, weighted toward runnable programs; retried while a candidate reads an unset entry
	function automatic instr_t pick_instr();
		instr_t c;
		result_t scratch;
		bit unsafe;
		int w;
		for (int tries = 0; tries < 200; tries++) begin
			w = $urandom_range(99);
			c.level = 2'($urandom_range(3));
			if (w < 25) begin
				c.opcode = OP_LIT;
				c.addr = 11'(($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(9));
			end else if (w < 55) begin
				c.opcode = OP_OPR;
				case ($urandom_range(9))
					0: c.addr = 11'($urandom_range(2047));
					1: c.addr = OPR_RET;
					default: c.addr = 11'($urandom_range(13));
				endcase
			end else if (w < 67) begin
				c.opcode = OP_LOD;
				c.addr = 11'(($urandom_range(15) == 0) ? $urandom_range(2047) : $urandom_range(8));
			end else if (w < 77) begin
				c.opcode = OP_STO;
				c.addr = 11'(($urandom_range(15) == 0) ? $urandom_range(2047) : $urandom_range(8));
			end else if (w < 82) begin
				c.opcode = OP_CAL;
				c.addr = 11'($urandom_range(2047));
			end else if (w < 87) begin
				c.opcode = OP_INT;
				c.addr = 11'(($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(4));
			end else if (w < 92) begin
				c.opcode = OP_JMP;
				c.addr = ($urandom_range(7) == 0) ? 11'd0 : 11'($urandom_range(2047));
			end else begin
				c.opcode = OP_JPC;
				c.addr = 11'($urandom_range(2047));
			end
			execute_instr(c, 1'b0, scratch, unsafe);
			if (!unsafe)
				return c;
		end
		// fallback: a literal push only ever reads the current top
		c = '{opcode: OP_LIT, level: 2'd0, addr: 11'd1};
		return c;
	endfunction

	// hand one request to the block and log what it should answer
	// valid stays up after the handshake until the next call or a drain drops it
	task automatic send_instr(input instr_t ins, input bit typed, input result_t want);
		result_t res;
		bit unsafe;
		while ($urandom_range(99) < send_idle) begin
			instr_ch.valid <= 1'b0;
			@(negedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.data <= ins;
		do
			@(posedge clk);
		while (!(instr_ch.valid && instr_ch.ready));
		execute_instr(ins, 1'b1, res, unsafe);
		expected_results.push_back(typed ? want : res);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		instr_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	// receiver side back-pressure
	always @(negedge clk)
		result_ch.ready <= ($urandom_range(99) >= recv_stall);

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				fails++;
				$display("%0t: unexpected result pc %0d top %0d", $realtime,
					result_ch.data.next_pc, $signed(result_ch.data.top_index));
			end else begin
				automatic result_t want = expected_results.pop_front();
				automatic result_t got = result_ch.data;
				if (got !== want) begin
					fails++;
					$display("%0t: mismatch expected pc %0d top %0d val %h base %0d halt %b flt %0d",
						$realtime, want.next_pc, $signed(want.top_index), want.top_value,
						want.base_now, want.halted, want.fault);
					$display("%0t: mismatch actual   pc %0d top %0d val %h base %0d halt %b flt %0d",
						$realtime, got.next_pc, $signed(got.top_index), got.top_value,
						got.base_now, got.halted, got.fault);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		instr_t ins;
		int per_phase;
		fails = 0;
		cycles = 0;
		send_idle = 0;
		recv_stall = 0;
		arst_n = 1'b0;
		instr_ch.valid = 1'b0;
		instr_ch.data = '0;
		result_ch.ready = 1'b0;
		pc_reg = '0;
		base_reg = '0;
		top_reg = -1;
		for (int i = 0; i < DEPTH; i++) begin
			stack_mem[i] = '0;
			stack_set[i] = (i >= 1 && i <= 3);
		end

		// underflow on an empty stack, then push, binary underflow and divide by zero
		add_typed(OP_OPR, 0, OPR_NEG, 1, -1, 0, 0, FLT_UNDER);
		add_typed(OP_JPC, 3, 2047, 2, -1, 0, 0, FLT_UNDER);
		add_typed(OP_LIT, 0, 2047, 3, 0, 2047, 0, FLT_NONE);
		add_typed(OP_OPR, 0, OPR_ADD, 4, 0, 2047, 0, FLT_UNDER);
		add_typed(OP_LIT, 0, 0, 5, 1, 0, 0, FLT_NONE);
		add_typed(OP_OPR, 0, OPR_DIV, 6, 0, 0, 0, FLT_DIV0);
		// build the most negative word and divide it by minus one
		add_row(OP_LIT, 0, 1024);
		add_row(OP_LIT, 0, 1024);
		add_row(OP_OPR, 0, OPR_MUL);
		add_row(OP_LIT, 0, 2047);
		add_row(OP_LIT, 0, 1);
		add_row(OP_OPR, 0, OPR_ADD);
		add_row(OP_OPR, 0, OPR_MUL);
		add_row(OP_LIT, 0, 1);
		add_row(OP_OPR, 0, OPR_NEG);
		add_row(OP_OPR, 0, OPR_DIV);
		// fill the stack through a call frame up to its last entry, then overflow a call and return
		add_row(OP_STO, 0, 2047);
		add_row(OP_INT, 0, 2047);
		add_row(OP_CAL, 0, 5);
		add_row(OP_LIT, 0, 7);
		add_row(OP_STO, 0, 2046);
		add_row(OP_INT, 0, 2048 - 1);
		add_row(OP_LIT, 0, 1);
		add_row(OP_CAL, 3, 9);
		add_row(OP_OPR, 0, OPR_RET);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_instr(directed_rows[i].ins, directed_rows[i].typed, directed_rows[i].want);

		per_phase = RAND_ITEMS / 5;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			case (n / per_phase)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 62; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 62; end
				3: begin send_idle = 37; recv_stall = 37; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			// hold off once until the block has answered everything
			if (n == per_phase)
				wait_drained();
			ins = pick_instr();
			send_instr(ins, 1'b0, '0);
		end

		wait_drained();
		repeat (60) @(posedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/pl0_pkg.sv
design/pl0_if.sv
design/pl0_div.sv
design/pl0_pcode_stack_machine.sv
dv/tb_pl0_pcode_stack_machine.sv
